// ===== src/fcc_pkg.sv =====
package fcc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_P = 2'd0,
    OP_LOAD_V = 2'd1,
    OP_BUILD  = 2'd2,
    OP_TEST   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        half_size;
  } in_req_t;

  typedef struct packed {
    logic       visible;
    logic [2:0] first_reject_plane;
    logic       zero_normal;
  } out_req_t;

  localparam int NUM_PLANES = 6;
  localparam logic [2:0] NO_REJECT = 3'd6;

  // Row combined with row 3 for each plane, and whether it is added
  function automatic logic [1:0] plane_row(input logic [2:0] p);
    logic [1:0] r;
    unique case (p)
      3'd0, 3'd1: r = 2'd2;
      3'd2, 3'd3: r = 2'd0;
      default:    r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic plane_add(input logic [2:0] p);
    logic a;
    unique case (p)
      3'd0, 3'd2, 3'd5: a = 1'b1;
      default:          a = 1'b0;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== src/frustum_cube_cull.sv =====
// Channel | dir | handshake               | payload
// in_     | in  | in_valid / in_ready     | in_req_t (op,row,col,value,centre,half_size)
// out_    | out | out_valid / out_ready   | out_req_t (visible,first_reject_plane,zero_normal)
// A load writes one element and completes; a cube test runs up to 6 planes x 4 products.
// A build runs 64 products for P*V, then per plane 3 squares, a 32-step square root
// and, unless the length is zero, 4 divides of 64 steps each, all on one multiplier
// and one divider. Reset clears stores, planes and the flag.
// in_ready is low from acceptance until the result is taken on out_.
module frustum_cube_cull import fcc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_req
);
  typedef enum logic [3:0] {
    S_IDLE, S_MM_MUL, S_MM_ACC, S_PL_COMP, S_SQ_MUL, S_SQ_ACC, S_SQRT, S_SQRT_W,
    S_DIV, S_DIV_W, S_T_MUL, S_T_ACC, S_DONE
  } state_t;

  state_t state_r;
  in_req_t req_r;
  logic signed [31:0] p_r [16];
  logic signed [31:0] v_r [16];
  logic signed [31:0] m_r [16];
  logic signed [31:0] pl_r [24];
  logic signed [31:0] comp_r [4];
  logic flag_r;
  logic [3:0] e_r;       // matrix element index
  logic [2:0] k_r;       // inner step
  logic [2:0] pi_r;      // plane index
  logic signed [67:0] acc_r;
  logic [63:0] len_r;
  out_req_t res_r;

  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  logic dstart, dsqrt, dbusy;
  logic [63:0] dnum, dres;
  logic [31:0] dden;
  logic signed [33:0] corner;
  logic signed [31:0] nsel;

  fcc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_r(mp));
  fcc_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .is_sqrt(dsqrt),
                 .num(dnum), .den(dden), .busy(dbusy), .res_r(dres));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_req   = res_r;

  // select normal component and cube corner for the test
  always_comb begin
    nsel = pl_r[{pi_r, 2'(k_r)}];
    if (k_r == 3'd0) corner = 34'(req_r.center_x);
    else if (k_r == 3'd1) corner = 34'(req_r.center_y);
    else corner = 34'(req_r.center_z);
    if (nsel >= 0) corner = corner + 34'(req_r.half_size);
    else corner = corner - 34'(req_r.half_size);
  end

  // operand routing for the shared multiplier
  always_comb begin
    ma = '0; mb = '0;
    unique case (state_r)
      S_MM_MUL: begin
        ma = 34'(p_r[{e_r[3:2], k_r[1:0]}]);
        mb = 34'(v_r[{k_r[1:0], e_r[1:0]}]);
      end
      S_SQ_MUL: begin
        ma = 34'(comp_r[k_r[1:0]]);
        mb = 34'(comp_r[k_r[1:0]]);
      end
      S_T_MUL: begin
        ma = 34'(nsel);
        mb = (k_r == 3'd3) ? (34'sd1 <<< FRAC_BITS) : corner;
      end
      default: ;
    endcase
  end

  logic signed [65:0] prod_fl;
  logic [63:0] absnum;
  logic signed [31:0] ci;
  logic signed [65:0] qs;
  assign prod_fl = 66'(mp >>> FRAC_BITS);
  assign ci = comp_r[k_r[1:0]];
  assign absnum = (ci < 0) ? (64'(-65'(ci)) << FRAC_BITS) : (64'(ci) << FRAC_BITS);
  assign dstart = (state_r == S_SQRT) || (state_r == S_DIV);
  assign dsqrt  = (state_r == S_SQRT);
  assign dnum   = (state_r == S_SQRT) ? 64'(acc_r) : absnum;
  assign dden   = len_r[31:0];
  assign qs     = (ci < 0) ? -66'(dres) : 66'(dres);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      flag_r  <= 1'b0;
      for (int i = 0; i < 16; i++) begin p_r[i] <= '0; v_r[i] <= '0; end
      for (int i = 0; i < 24; i++) pl_r[i] <= '0;
      e_r <= '0; k_r <= '0; pi_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          req_r <= in_req;
          res_r <= '{visible: 1'b0, first_reject_plane: NO_REJECT, zero_normal: 1'b0};
          e_r <= '0; k_r <= '0; pi_r <= '0; acc_r <= '0;
          unique case (op_t'(in_req.op))
            OP_LOAD_P: begin p_r[{in_req.row, in_req.col}] <= in_req.value; state_r <= S_DONE; end
            OP_LOAD_V: begin v_r[{in_req.row, in_req.col}] <= in_req.value; state_r <= S_DONE; end
            OP_BUILD:  begin flag_r <= 1'b0; state_r <= S_MM_MUL; end
            default:   state_r <= S_T_MUL;
          endcase
        end
        // P*V: each product floored, then summed
        S_MM_MUL: state_r <= S_MM_ACC;
        S_MM_ACC: begin
          if (k_r == 3'd3) begin
            m_r[e_r] <= sat32(66'(acc_r) + prod_fl);
            acc_r <= '0; k_r <= '0;
            if (e_r == 4'd15) begin
              pi_r <= '0; state_r <= S_PL_COMP;
            end else begin
              e_r <= e_r + 4'd1; state_r <= S_MM_MUL;
            end
          end else begin
            acc_r <= 68'(66'(acc_r) + prod_fl);
            k_r <= k_r + 3'd1; state_r <= S_MM_MUL;
          end
        end
        // raw plane components from row 3 and the partner row
        S_PL_COMP: begin
          for (int c = 0; c < 4; c++) begin
            if (plane_add(pi_r))
              comp_r[c] <= sat32(66'(m_r[12 + c]) + 66'(m_r[{plane_row(pi_r), 2'(c)}]));
            else
              comp_r[c] <= sat32(66'(m_r[12 + c]) - 66'(m_r[{plane_row(pi_r), 2'(c)}]));
          end
          acc_r <= '0; k_r <= '0; state_r <= S_SQ_MUL;
        end
        S_SQ_MUL: state_r <= S_SQ_ACC;
        S_SQ_ACC: begin
          acc_r <= acc_r + 68'(mp[63:0]);
          if (k_r == 3'd2) state_r <= S_SQRT;
          else begin k_r <= k_r + 3'd1; state_r <= S_SQ_MUL; end
        end
        S_SQRT: state_r <= S_SQRT_W;
        S_SQRT_W: if (!dbusy) begin
          len_r <= dres;
          k_r <= '0;
          if (dres == 64'd0) begin
            flag_r <= 1'b1;
            for (int c = 0; c < 4; c++) pl_r[{pi_r, 2'(c)}] <= comp_r[c];
            if (pi_r == 3'(NUM_PLANES - 1)) begin
              res_r.zero_normal <= 1'b1; state_r <= S_DONE;
            end else begin
              pi_r <= pi_r + 3'd1; state_r <= S_PL_COMP;
            end
          end else state_r <= S_DIV;
        end
        S_DIV: state_r <= S_DIV_W;
        S_DIV_W: if (!dbusy) begin
          pl_r[{pi_r, k_r[1:0]}] <= sat32(qs);
          if (k_r == 3'd3) begin
            if (pi_r == 3'(NUM_PLANES - 1)) begin
              res_r.zero_normal <= flag_r; state_r <= S_DONE;
            end else begin
              pi_r <= pi_r + 3'd1; state_r <= S_PL_COMP;
            end
          end else begin
            k_r <= k_r + 3'd1; state_r <= S_DIV;
          end
        end
        // cube test: three corner products plus w, exact
        S_T_MUL: state_r <= S_T_ACC;
        S_T_ACC: begin
          if (k_r == 3'd3) begin
            if (acc_r + mp < 0) begin
              res_r.first_reject_plane <= pi_r; state_r <= S_DONE;
            end else if (pi_r == 3'(NUM_PLANES - 1)) begin
              res_r.visible <= 1'b1; state_r <= S_DONE;
            end else begin
              pi_r <= pi_r + 3'd1; k_r <= '0; acc_r <= '0; state_r <= S_T_MUL;
            end
          end else begin
            acc_r <= acc_r + mp; k_r <= k_r + 3'd1; state_r <= S_T_MUL;
          end
        end
        S_DONE: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_vis_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.visible |-> out_req.first_reject_plane == NO_REJECT);
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    dstart |-> !dbusy) else $error("divider restarted while busy");
endmodule

// ===== src/fcc_mul.sv =====
// Shared 34x34 signed multiplier, result registered
module fcc_mul import fcc_pkg::*; (
  input  logic               clk,
  input  logic signed [33:0] a,
  input  logic signed [33:0] b,
  output logic signed [67:0] p_r
);
  logic signed [67:0] p_nxt;
  assign p_nxt = a * b;
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end
endmodule

// ===== src/fcc_div.sv =====
// Iterative restoring divider and square root, one bit per cycle
module fcc_div import fcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        is_sqrt,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [63:0] res_r
);
  logic [63:0] rem_r, rem_nxt, q_nxt, rad_r, rad_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        sq_r, busy_r, busy_nxt;
  logic [65:0] trial;
  logic [65:0] remsh;

  assign busy = busy_r;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = res_r;
    rad_nxt  = rad_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    remsh    = '0;
    trial    = '0;
    if (start) begin
      rem_nxt = '0; q_nxt = '0; rad_nxt = num;
      cnt_nxt = is_sqrt ? 7'd32 : 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sq_r) begin
        // two radicand bits per step
        remsh = {rem_r, rad_r[63:62]};
        trial = {res_r[63:0], 2'b01};
        rad_nxt = {rad_r[61:0], 2'b00};
        if (remsh >= trial) begin
          rem_nxt = 64'(remsh - trial);
          q_nxt = {res_r[62:0], 1'b1};
        end else begin
          rem_nxt = remsh[63:0];
          q_nxt = {res_r[62:0], 1'b0};
        end
      end else begin
        remsh = {1'b0, rem_r, rad_r[63]};
        trial = {34'd0, den};
        rad_nxt = {rad_r[62:0], 1'b0};
        if (remsh >= trial) begin
          rem_nxt = 64'(remsh - trial);
          q_nxt = {res_r[62:0], 1'b1};
        end else begin
          rem_nxt = remsh[63:0];
          q_nxt = {res_r[62:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (start) sq_r <= is_sqrt;
    rem_r <= rem_nxt;
    res_r <= q_nxt;
    rad_r <= rad_nxt;
  end
endmodule
